### rtl/core/segment_intersection_assert.svh
// Assertion macros shared by the segment intersection RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_INTERSECTION_ASSERT_SVH

// Same-cycle implication.
`define SI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/si_pkg.sv
package si_pkg;

	// Coordinate width of every point field.
	localparam int CW = 48;

	// Configuration port.
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_X_TOL   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAR_TOL = 1'd1;

	// Stream payload widths.
	localparam int S_DATA_W = 8 * CW;
	localparam int M_DATA_W = ((1 + 2 * CW + 7) / 8) * 8;

	// Operand slice sizes of the pipelined multiplier.
	localparam int MUL_A_CHUNK = 32;
	localparam int MUL_B_CHUNK = 24;

endpackage

### rtl/core/si_div.sv
// Unsigned restoring divider, one quotient bit per pipeline stage.
// The first remainder is given by the caller so that a division can start
// partway through a wide numerator.
module si_div #(
	parameter int N_W    = 81,
	parameter int D_W    = 49,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [N_W-1:0]    num,
	input  logic [D_W-1:0]    rem0,
	input  logic [D_W-1:0]    den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [N_W-1:0]    quo,
	output logic [SIDE_W-1:0] side_out
);

	logic              v_s    [1:N_W];
	logic [N_W-1:0]    num_s  [1:N_W];
	logic [D_W-1:0]    rem_s  [1:N_W];
	logic [D_W-1:0]    den_s  [1:N_W];
	logic [N_W-1:0]    quo_s  [1:N_W];
	logic [SIDE_W-1:0] side_s [1:N_W];

	for (genvar k = 0; k < N_W; k++) begin : g_stage
		logic              cur_v;
		logic [N_W-1:0]    cur_num;
		logic [D_W-1:0]    cur_rem;
		logic [D_W-1:0]    cur_den;
		logic [N_W-1:0]    cur_quo;
		logic [SIDE_W-1:0] cur_side;
		logic [D_W:0]      trial;
		logic [D_W:0]      diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_v    = in_valid;
			assign cur_num  = num;
			assign cur_rem  = rem0;
			assign cur_den  = den;
			assign cur_quo  = '0;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_v    = v_s[k];
			assign cur_num  = num_s[k];
			assign cur_rem  = rem_s[k];
			assign cur_den  = den_s[k];
			assign cur_quo  = quo_s[k];
			assign cur_side = side_s[k];
		end

		assign trial = {cur_rem, cur_num[N_W-1]};
		assign diff  = trial - {1'b0, cur_den};
		assign ge    = trial >= {1'b0, cur_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1]  <= cur_num << 1;
				rem_s[k+1]  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
				den_s[k+1]  <= cur_den;
				quo_s[k+1]  <= {cur_quo[N_W-2:0], ge};
				side_s[k+1] <= cur_side;
			end
		end
	end

	assign out_valid = v_s[N_W];
	assign quo       = quo_s[N_W];
	assign side_out  = side_s[N_W];

endmodule

### rtl/core/si_mul.sv
// Unsigned multiplier that adds one slice product per pipeline stage.
module si_mul #(
	parameter int A_W    = 81,
	parameter int B_W    = 48,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [A_W-1:0]    a,
	input  logic [B_W-1:0]    b,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [A_W+B_W-1:0] prod,
	output logic [SIDE_W-1:0] side_out
);

	import si_pkg::*;

	localparam int NA  = (A_W + MUL_A_CHUNK - 1) / MUL_A_CHUNK;
	localparam int NB  = (B_W + MUL_B_CHUNK - 1) / MUL_B_CHUNK;
	localparam int NS  = NA * NB;
	localparam int P_W = A_W + B_W;
	localparam int TW  = NA * MUL_A_CHUNK + NB * MUL_B_CHUNK;

	logic              v_s    [1:NS];
	logic [A_W-1:0]    a_s    [1:NS];
	logic [B_W-1:0]    b_s    [1:NS];
	logic [P_W-1:0]    acc_s  [1:NS];
	logic [SIDE_W-1:0] side_s [1:NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int IA = k / NB;
		localparam int IB = k % NB;
		localparam int SH = IA * MUL_A_CHUNK + IB * MUL_B_CHUNK;

		logic                               cur_v;
		logic [A_W-1:0]                     cur_a;
		logic [B_W-1:0]                     cur_b;
		logic [P_W-1:0]                     cur_acc;
		logic [SIDE_W-1:0]                  cur_side;
		logic [NA*MUL_A_CHUNK-1:0]          a_pad;
		logic [NB*MUL_B_CHUNK-1:0]          b_pad;
		logic [MUL_A_CHUNK+MUL_B_CHUNK-1:0] pp;
		logic [TW-1:0]                      term;

		if (k == 0) begin : g_first
			assign cur_v    = in_valid;
			assign cur_a    = a;
			assign cur_b    = b;
			assign cur_acc  = '0;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_v    = v_s[k];
			assign cur_a    = a_s[k];
			assign cur_b    = b_s[k];
			assign cur_acc  = acc_s[k];
			assign cur_side = side_s[k];
		end

		assign a_pad = (NA*MUL_A_CHUNK)'(cur_a);
		assign b_pad = (NB*MUL_B_CHUNK)'(cur_b);
		assign pp    = a_pad[IA*MUL_A_CHUNK +: MUL_A_CHUNK] * b_pad[IB*MUL_B_CHUNK +: MUL_B_CHUNK];
		assign term  = TW'(pp) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k+1]    <= cur_a;
				b_s[k+1]    <= cur_b;
				acc_s[k+1]  <= cur_acc + term[P_W-1:0];
				side_s[k+1] <= cur_side;
			end
		end
	end

	assign out_valid = v_s[NS];
	assign prod      = acc_s[NS];
	assign side_out  = side_s[NS];

endmodule

### rtl/core/segment_intersection.sv
// The slope dividers take CW + 1 + SLOPE_FRAC_BITS stages and the crossing divider 48.
// Throughput: one segment pair per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset: arst_n clears all valid bits and sets both tolerances to 1.
`include "segment_intersection_assert.svh"

module segment_intersection #(
	parameter int SLOPE_FRAC_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [si_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [si_pkg::CFG_W-1:0]      cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// design_start_x, design_start_y, design_end_x, design_end_y,
	// ground_start_x, ground_start_y, ground_end_x, ground_end_y
	input  logic [si_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// found, cross_x, cross_y, zero fill
	output logic [si_pkg::M_DATA_W-1:0]   m_tdata
);

	import si_pkg::*;

	localparam int SF  = SLOPE_FRAC_BITS;
	localparam int DW  = CW + 1;          // coordinate difference
	localparam int SMW = DW + SF;         // slope magnitude
	localparam int SW  = SMW + 1;         // signed slope
	localparam int FW  = SW + 1;          // slope difference
	localparam int PW  = SMW + CW;        // product magnitude
	localparam int BW  = PW + 2;          // intercept
	localparam int NW  = BW + 1;          // intercept difference
	localparam int XQ  = CW;              // crossing quotient bits
	localparam int XW  = XQ + 1;          // signed crossing x
	localparam int EW  = XW + 1;          // span test width
	localparam int YW  = BW + 1 - SF;     // y before saturation

	typedef struct packed {
		logic          negd;
		logic          vert;
		logic [CW-1:0] dex;
		logic [CW-1:0] dey;
		logic [CW-1:0] gex;
		logic [CW-1:0] gey;
		logic [CW-1:0] dmin;
		logic [CW-1:0] dmax;
		logic [CW-1:0] gmin;
		logic [CW-1:0] gmax;
	} sdiv_side_t;

	typedef struct packed {
		logic           negd;
		logic           vert;
		logic           pdneg;
		logic [SW-1:0]  sd;
		logic [SW-1:0]  sg;
		logic [SMW-1:0] qd;
		logic [CW-1:0]  dey;
		logic [CW-1:0]  gey;
		logic [CW-1:0]  dmin;
		logic [CW-1:0]  dmax;
		logic [CW-1:0]  gmin;
		logic [CW-1:0]  gmax;
	} mul1_side_t;

	typedef struct packed {
		logic           fail;
		logic           xneg;
		logic           negd;
		logic [BW-1:0]  bd;
		logic [SMW-1:0] qd;
		logic [CW-1:0]  dmin;
		logic [CW-1:0]  dmax;
		logic [CW-1:0]  gmin;
		logic [CW-1:0]  gmax;
	} xdiv_side_t;

	typedef struct packed {
		logic          fail;
		logic          psign;
		logic [XW-1:0] x;
		logic [BW-1:0] bd;
	} ymul_side_t;

	logic en;
	logic [CFG_W-1:0] xtol_q, ptol_q;

	// Input fields.
	logic [CW-1:0] dsx, dsy, dex, dey, gsx, gsy, gex, gey;
	assign dsx = s_tdata[0*CW +: CW];
	assign dsy = s_tdata[1*CW +: CW];
	assign dex = s_tdata[2*CW +: CW];
	assign dey = s_tdata[3*CW +: CW];
	assign gsx = s_tdata[4*CW +: CW];
	assign gsy = s_tdata[5*CW +: CW];
	assign gex = s_tdata[6*CW +: CW];
	assign gey = s_tdata[7*CW +: CW];

	logic out_valid_q;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xtol_q <= CFG_W'(1);
			ptol_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_TOL:   xtol_q <= cfg_data;
				REG_PAR_TOL: ptol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: coordinate differences.
	logic          v_s1, vert_s1;
	logic [DW-1:0] dxd_s1, dyd_s1, dxg_s1, dyg_s1;
	logic [CW-1:0] dsx_s1, dex_s1, dey_s1, gsx_s1, gex_s1, gey_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dxd_s1  <= {dex[CW-1], dex} - {dsx[CW-1], dsx};
			dyd_s1  <= {dey[CW-1], dey} - {dsy[CW-1], dsy};
			dxg_s1  <= {gex[CW-1], gex} - {gsx[CW-1], gsx};
			dyg_s1  <= {gey[CW-1], gey} - {gsy[CW-1], gsy};
			vert_s1 <= (dex == dsx) || (gex == gsx);
			dsx_s1  <= dsx;
			dex_s1  <= dex;
			dey_s1  <= dey;
			gsx_s1  <= gsx;
			gex_s1  <= gex;
			gey_s1  <= gey;
		end
	end

	// Stage 2: magnitudes, slope signs and span limits.
	logic          v_s2;
	logic [DW-1:0] adxd_s2, adyd_s2, adxg_s2, adyg_s2;
	sdiv_side_t    sdside_s2;
	logic          negg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			adxd_s2 <= dxd_s1[DW-1] ? -dxd_s1 : dxd_s1;
			adyd_s2 <= dyd_s1[DW-1] ? -dyd_s1 : dyd_s1;
			adxg_s2 <= dxg_s1[DW-1] ? -dxg_s1 : dxg_s1;
			adyg_s2 <= dyg_s1[DW-1] ? -dyg_s1 : dyg_s1;
			negg_s2 <= dyg_s1[DW-1] ^ dxg_s1[DW-1];
			sdside_s2.negd <= dyd_s1[DW-1] ^ dxd_s1[DW-1];
			sdside_s2.vert <= vert_s1;
			sdside_s2.dex  <= dex_s1;
			sdside_s2.dey  <= dey_s1;
			sdside_s2.gex  <= gex_s1;
			sdside_s2.gey  <= gey_s1;
			sdside_s2.dmin <= ($signed(dsx_s1) <= $signed(dex_s1)) ? dsx_s1 : dex_s1;
			sdside_s2.dmax <= ($signed(dsx_s1) <= $signed(dex_s1)) ? dex_s1 : dsx_s1;
			sdside_s2.gmin <= ($signed(gsx_s1) <= $signed(gex_s1)) ? gsx_s1 : gex_s1;
			sdside_s2.gmax <= ($signed(gsx_s1) <= $signed(gex_s1)) ? gex_s1 : gsx_s1;
		end
	end

	// Slope dividers.
	logic           sdv_valid;
	logic [SMW-1:0] qd_dv, qg_dv;
	sdiv_side_t     sdside_dv;
	logic           negg_dv;

	si_div #(.N_W(SMW), .D_W(DW), .SIDE_W($bits(sdiv_side_t))) u_div_sd (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.num({adyd_s2, {SF{1'b0}}}), .rem0('0), .den(adxd_s2),
		.side_in(sdside_s2), .out_valid(sdv_valid), .quo(qd_dv), .side_out(sdside_dv)
	);

	si_div #(.N_W(SMW), .D_W(DW), .SIDE_W(1)) u_div_sg (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.num({adyg_s2, {SF{1'b0}}}), .rem0('0), .den(adxg_s2),
		.side_in(negg_s2), .out_valid(), .quo(qg_dv), .side_out(negg_dv)
	);

	// Stage 3: signed slopes and multiplier operands.
	logic           v_s3, pgneg_s3;
	logic [SMW-1:0] qg_s3;
	logic [CW-1:0]  adex_s3, agex_s3;
	mul1_side_t     m1side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			m1side_s3.negd  <= sdside_dv.negd;
			m1side_s3.vert  <= sdside_dv.vert;
			m1side_s3.pdneg <= sdside_dv.negd ^ sdside_dv.dex[CW-1];
			m1side_s3.sd    <= sdside_dv.negd ? -{1'b0, qd_dv} : {1'b0, qd_dv};
			m1side_s3.sg    <= negg_dv ? -{1'b0, qg_dv} : {1'b0, qg_dv};
			m1side_s3.qd    <= qd_dv;
			m1side_s3.dey   <= sdside_dv.dey;
			m1side_s3.gey   <= sdside_dv.gey;
			m1side_s3.dmin  <= sdside_dv.dmin;
			m1side_s3.dmax  <= sdside_dv.dmax;
			m1side_s3.gmin  <= sdside_dv.gmin;
			m1side_s3.gmax  <= sdside_dv.gmax;
			pgneg_s3 <= negg_dv ^ sdside_dv.gex[CW-1];
			qg_s3    <= qg_dv;
			adex_s3  <= sdside_dv.dex[CW-1] ? -sdside_dv.dex : sdside_dv.dex;
			agex_s3  <= sdside_dv.gex[CW-1] ? -sdside_dv.gex : sdside_dv.gex;
		end
	end

	// Slope times end x for both intercepts.
	logic          m1_valid, pgneg_m1;
	logic [PW-1:0] pd_m1, pg_m1;
	mul1_side_t    m1side_m1;

	si_mul #(.A_W(SMW), .B_W(CW), .SIDE_W($bits(mul1_side_t))) u_mul_bd (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.a(m1side_s3.qd), .b(adex_s3), .side_in(m1side_s3),
		.out_valid(m1_valid), .prod(pd_m1), .side_out(m1side_m1)
	);

	si_mul #(.A_W(SMW), .B_W(CW), .SIDE_W(1)) u_mul_bg (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.a(qg_s3), .b(agex_s3), .side_in(pgneg_s3),
		.out_valid(), .prod(pg_m1), .side_out(pgneg_m1)
	);

	// Stage 4: signed products and slope difference.
	logic           v_s4, vert_s4, negd_s4;
	logic [PW:0]    pd_s4, pg_s4;
	logic [FW-1:0]  dif_s4;
	logic [SMW-1:0] qd_s4;
	logic [CW-1:0]  dey_s4, gey_s4, dmin_s4, dmax_s4, gmin_s4, gmax_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pd_s4   <= m1side_m1.pdneg ? -{1'b0, pd_m1} : {1'b0, pd_m1};
			pg_s4   <= pgneg_m1 ? -{1'b0, pg_m1} : {1'b0, pg_m1};
			dif_s4  <= {m1side_m1.sg[SW-1], m1side_m1.sg} - {m1side_m1.sd[SW-1], m1side_m1.sd};
			vert_s4 <= m1side_m1.vert;
			negd_s4 <= m1side_m1.negd;
			qd_s4   <= m1side_m1.qd;
			dey_s4  <= m1side_m1.dey;
			gey_s4  <= m1side_m1.gey;
			dmin_s4 <= m1side_m1.dmin;
			dmax_s4 <= m1side_m1.dmax;
			gmin_s4 <= m1side_m1.gmin;
			gmax_s4 <= m1side_m1.gmax;
		end
	end

	// Stage 5: intercepts and the parallel test.
	logic           v_s5, fail_s5, difneg_s5, negd_s5;
	logic [BW-1:0]  bd_s5, bg_s5;
	logic [FW-1:0]  adif_s5;
	logic [SMW-1:0] qd_s5;
	logic [CW-1:0]  dmin_s5, dmax_s5, gmin_s5, gmax_s5;
	logic [FW-1:0]  adif_c;

	assign adif_c = dif_s4[FW-1] ? -dif_s4 : dif_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			bd_s5 <= {{(BW-CW-SF){dey_s4[CW-1]}}, dey_s4, {SF{1'b0}}}
				- {{(BW-PW-1){pd_s4[PW]}}, pd_s4};
			bg_s5 <= {{(BW-CW-SF){gey_s4[CW-1]}}, gey_s4, {SF{1'b0}}}
				- {{(BW-PW-1){pg_s4[PW]}}, pg_s4};
			adif_s5   <= adif_c;
			difneg_s5 <= dif_s4[FW-1];
			fail_s5   <= vert_s4 || (dif_s4 == '0) || (adif_c < FW'(ptol_q));
			negd_s5   <= negd_s4;
			qd_s5     <= qd_s4;
			dmin_s5   <= dmin_s4;
			dmax_s5   <= dmax_s4;
			gmin_s5   <= gmin_s4;
			gmax_s5   <= gmax_s4;
		end
	end

	// Stage 6: intercept difference and the sign of x.
	logic           v_s6, fail_s6, xneg_s6, negd_s6;
	logic [NW-1:0]  num_s6;
	logic [BW-1:0]  bd_s6;
	logic [FW-1:0]  adif_s6;
	logic [SMW-1:0] qd_s6;
	logic [CW-1:0]  dmin_s6, dmax_s6, gmin_s6, gmax_s6;
	logic [NW-1:0]  num_c;

	assign num_c = {bd_s5[BW-1], bd_s5} - {bg_s5[BW-1], bg_s5};

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6  <= num_c;
			xneg_s6 <= num_c[NW-1] ^ difneg_s5;
			fail_s6 <= fail_s5;
			negd_s6 <= negd_s5;
			bd_s6   <= bd_s5;
			adif_s6 <= adif_s5;
			qd_s6   <= qd_s5;
			dmin_s6 <= dmin_s5;
			dmax_s6 <= dmax_s5;
			gmin_s6 <= gmin_s5;
			gmax_s6 <= gmax_s5;
		end
	end

	// Stage 7: numerator magnitude.
	logic           v_s7;
	logic [NW-1:0]  anum_s7;
	logic [FW-1:0]  adif_s7;
	xdiv_side_t     xside_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			anum_s7       <= num_s6[NW-1] ? -num_s6 : num_s6;
			adif_s7       <= adif_s6;
			xside_s7.fail <= fail_s6;
			xside_s7.xneg <= xneg_s6;
			xside_s7.negd <= negd_s6;
			xside_s7.bd   <= bd_s6;
			xside_s7.qd   <= qd_s6;
			xside_s7.dmin <= dmin_s6;
			xside_s7.dmax <= dmax_s6;
			xside_s7.gmin <= gmin_s6;
			xside_s7.gmax <= gmax_s6;
		end
	end

	// Stage 8: a quotient of 2^XQ or more cannot lie in either span.
	logic           v_s8;
	logic [XQ-1:0]  numlo_s8;
	logic [FW-1:0]  rem0_s8, adif_s8;
	xdiv_side_t     xside_s8;
	logic [NW-1:0]  anum_hi;

	assign anum_hi = anum_s7 >> XQ;

	always_ff @(posedge clk) begin
		if (en) begin
			numlo_s8      <= anum_s7[XQ-1:0];
			rem0_s8       <= anum_hi[FW-1:0];
			adif_s8       <= adif_s7;
			xside_s8.fail <= xside_s7.fail || (anum_hi >= NW'(adif_s7));
			xside_s8.xneg <= xside_s7.xneg;
			xside_s8.negd <= xside_s7.negd;
			xside_s8.bd   <= xside_s7.bd;
			xside_s8.qd   <= xside_s7.qd;
			xside_s8.dmin <= xside_s7.dmin;
			xside_s8.dmax <= xside_s7.dmax;
			xside_s8.gmin <= xside_s7.gmin;
			xside_s8.gmax <= xside_s7.gmax;
		end
	end

	// Crossing divider.
	logic          xdv_valid;
	logic [XQ-1:0] qx_dv;
	xdiv_side_t    xside_dv;

	si_div #(.N_W(XQ), .D_W(FW), .SIDE_W($bits(xdiv_side_t))) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s8),
		.num(numlo_s8), .rem0(rem0_s8), .den(adif_s8),
		.side_in(xside_s8), .out_valid(xdv_valid), .quo(qx_dv), .side_out(xside_dv)
	);

	// Stage 9: signed x.
	logic           v_s9, fail_s9, psign_s9;
	logic [XW-1:0]  x_s9;
	logic [XQ-1:0]  qx_s9;
	logic [BW-1:0]  bd_s9;
	logic [SMW-1:0] qd_s9;
	logic [CW-1:0]  dmin_s9, dmax_s9, gmin_s9, gmax_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s9     <= xside_dv.xneg ? -{1'b0, qx_dv} : {1'b0, qx_dv};
			qx_s9    <= qx_dv;
			psign_s9 <= xside_dv.xneg ^ xside_dv.negd;
			fail_s9  <= xside_dv.fail;
			bd_s9    <= xside_dv.bd;
			qd_s9    <= xside_dv.qd;
			dmin_s9  <= xside_dv.dmin;
			dmax_s9  <= xside_dv.dmax;
			gmin_s9  <= xside_dv.gmin;
			gmax_s9  <= xside_dv.gmax;
		end
	end

	// Stage 10: span test against both widened x ranges.
	logic           v_s10;
	logic [SMW-1:0] qd_s10;
	logic [XQ-1:0]  qx_s10;
	ymul_side_t     yside_s10;
	logic [EW-1:0]  xe, tole, xp, xm, dmn, dmx, gmn, gmx;
	logic           span_ok;

	always_comb begin
		xe   = {x_s9[XW-1], x_s9};
		tole = EW'(xtol_q);
		xp   = xe + tole;
		xm   = xe - tole;
		dmn  = {{(EW-CW){dmin_s9[CW-1]}}, dmin_s9};
		dmx  = {{(EW-CW){dmax_s9[CW-1]}}, dmax_s9};
		gmn  = {{(EW-CW){gmin_s9[CW-1]}}, gmin_s9};
		gmx  = {{(EW-CW){gmax_s9[CW-1]}}, gmax_s9};
		span_ok = ($signed(xp) >= $signed(dmn)) && ($signed(xm) <= $signed(dmx))
			&& ($signed(xp) >= $signed(gmn)) && ($signed(xm) <= $signed(gmx));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qd_s10          <= qd_s9;
			qx_s10          <= qx_s9;
			yside_s10.fail  <= fail_s9 || !span_ok;
			yside_s10.psign <= psign_s9;
			yside_s10.x     <= x_s9;
			yside_s10.bd    <= bd_s9;
		end
	end

	// x times the design slope.
	logic          ym_valid;
	logic [PW-1:0] py_m;
	ymul_side_t    yside_m;

	si_mul #(.A_W(SMW), .B_W(XQ), .SIDE_W($bits(ymul_side_t))) u_mul_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s10),
		.a(qd_s10), .b(qx_s10), .side_in(yside_s10),
		.out_valid(ym_valid), .prod(py_m), .side_out(yside_m)
	);

	// Stage 11: signed product.
	logic          v_s11, fail_s11;
	logic [PW:0]   yp_s11;
	logic [XW-1:0] x_s11;
	logic [BW-1:0] bd_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			yp_s11   <= yside_m.psign ? -{1'b0, py_m} : {1'b0, py_m};
			fail_s11 <= yside_m.fail;
			x_s11    <= yside_m.x;
			bd_s11   <= yside_m.bd;
		end
	end

	// Stage 12: add the intercept and drop the slope fraction (floor).
	logic          v_s12, fail_s12;
	logic [YW-1:0] y_s12;
	logic [XW-1:0] x_s12;
	logic [BW:0]   ysum;

	assign ysum = {{(BW-PW){yp_s11[PW]}}, yp_s11} + {bd_s11[BW-1], bd_s11};

	always_ff @(posedge clk) begin
		if (en) begin
			y_s12    <= ysum[BW:SF];
			fail_s12 <= fail_s11;
			x_s12    <= x_s11;
		end
	end

	// Saturation to the coordinate range.
	localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	logic [CW-1:0] xsat, ysat;
	logic          x_fits, y_fits;

	always_comb begin
		x_fits = (&x_s12[XW-1:CW-1]) || !(|x_s12[XW-1:CW-1]);
		y_fits = (&y_s12[YW-1:CW-1]) || !(|y_s12[YW-1:CW-1]);
		xsat   = x_fits ? x_s12[CW-1:0] : (x_s12[XW-1] ? CMIN : CMAX);
		ysat   = y_fits ? y_s12[CW-1:0] : (y_s12[YW-1] ? CMIN : CMAX);
	end

	// Output register.
	logic          found_q;
	logic [CW-1:0] cross_x_q, cross_y_q;

	always_ff @(posedge clk) begin
		if (en) begin
			found_q   <= !fail_s12;
			cross_x_q <= fail_s12 ? '0 : xsat;
			cross_y_q <= fail_s12 ? '0 : ysat;
		end
	end

	// Valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			v_s10       <= 1'b0;
			v_s11       <= 1'b0;
			v_s12       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= s_tvalid;
			v_s2        <= v_s1;
			v_s3        <= sdv_valid;
			v_s4        <= m1_valid;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= xdv_valid;
			v_s10       <= v_s9;
			v_s11       <= ym_valid;
			v_s12       <= v_s11;
			out_valid_q <= v_s12;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W-1-2*CW){1'b0}}, cross_y_q, cross_x_q, found_q};

	`SI_ASSERT_IMP(a_zero_when_missed, out_valid_q && !found_q, (cross_x_q == '0) && (cross_y_q == '0), "result without crossing has nonzero coordinates")
	`SI_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, v_s1, "accepted transaction did not enter the pipeline")
	`SI_ASSERT_NXT(a_stall_holds, !en, $stable(v_s12) && (!v_s12 || $stable(fail_s12)), "last stage changed during a stall")

endmodule
